// ===== design/huffman_tree_load_and_decode_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman tree loader and decoder
// Shared forms for the concurrent checks of the block's port behavior.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_ASSERT_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define HUFD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define HUFD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hufd_pkg.sv =====
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and constants of the Huffman tree loader and decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

    typedef enum logic [1:0] {
        OP_TOKEN  = 2'd0,
        OP_BIT    = 2'd1,
        OP_FINISH = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_SYMBOL   = 3'd0,
        KIND_READY    = 3'd1,
        KIND_OK       = 3'd2,
        KIND_MISMATCH = 3'd3,
        KIND_OVERFLOW = 3'd4,
        KIND_NOTREE   = 3'd5
    } kind_t;

    // Serialized-tree byte that announces a leaf ('L').
    localparam logic [7:0] LEAF_MARK = 8'h4C;

    // Output queue sizing.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // One result request; kind sits in the low bits.
    typedef struct packed {
        logic [7:0] symbol;
        kind_t      kind;
    } result_t;

    // Result produced by the tree loader for a token.
    typedef struct packed {
        logic  valid;
        kind_t kind;
    } load_res_t;

    // Tree status handed from the loader to the decoder.
    typedef struct packed {
        logic       complete;
        logic       root_leaf;
        logic [7:0] root_sym;
    } tree_stat_t;

endpackage

// ===== design/huffman_tree_load_and_decode.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode
// Huffman tree loader and bit-serial decoder with stream request channels.
// ----------------------------------------------------------------------------
// Usage:
//   Send requests on s_*: op 0 loads one preorder tree byte ('L' then the
//   symbol makes a leaf, any other byte an internal node), op 1 decodes one
//   code bit, op 2 finishes a stream, op 3 clears tree and decoder.
//   Results leave on m_*: symbol, tree ready, stream ok, mismatch, overflow
//   or no usable tree; a request yields at most one result.
//   A result passes the input register, the result stage (with the node and
//   stack reads registered) and the output queue on its way to m_tvalid.
//   Throughput: one request per cycle while s_tready is high. The node
//   memory read for a bit is resolved in the result stage and forwarded
//   straight into the next bit's read address; consecutive bits never wait.
//   Reset clears all control state; the node table and parent stack need
//   no clearing, the fill count and stack level cover them.
//   When the receiver stalls, results collect in a 4-entry queue; s_tready
//   drops once the queue plus requests still in flight could fill it.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode #(
    parameter int MAX_NODES   = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] op, [9:2] token, [10] code_bit, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] kind, [10:3] symbol, [15:11] zero
);

    localparam int NODE_W = $clog2(MAX_NODES);

    // Input register: one request in flight here per cycle.
    logic            p_valid_reg;
    hufd_pkg::op_t   p_op_reg;
    logic [7:0]      p_token_reg;
    logic            p_bit_reg;
    logic            s_accept;

    // Loader to node table and decoder.
    logic                 sym_we;
    logic [NODE_W-1:0]    sym_waddr;
    logic [8:0]           sym_wdata;
    logic                 left_we;
    logic                 right_we;
    logic [NODE_W-1:0]    link_waddr;
    logic [NODE_W-1:0]    link_wdata;
    hufd_pkg::tree_stat_t stat;
    logic [NODE_W-1:0]    root_left;
    logic [NODE_W-1:0]    root_right;
    hufd_pkg::load_res_t  load_res;

    // Node table read port.
    logic [NODE_W-1:0]    nt_raddr;
    logic                 rd_leaf;
    logic [7:0]           rd_sym;
    logic [NODE_W-1:0]    rd_left;
    logic [NODE_W-1:0]    rd_right;

    // Result stage and output queue.
    logic                           r_valid;
    logic                           push;
    hufd_pkg::result_t              push_data;
    hufd_pkg::result_t              out_data;
    logic [hufd_pkg::OUT_CNT_W-1:0] out_count;
    logic [hufd_pkg::OUT_CNT_W-1:0] occupancy;

    // Admit a request only if the queue can take every result in flight.
    assign occupancy = out_count + hufd_pkg::OUT_CNT_W'(p_valid_reg)
                       + hufd_pkg::OUT_CNT_W'(r_valid);
    assign s_tready  = occupancy < hufd_pkg::OUT_CNT_W'(hufd_pkg::OUT_DEPTH);
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= s_accept;
        end
    end

    // Capture payload on accept; hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_op_reg    <= hufd_pkg::op_t'(s_tdata[1:0]);
            p_token_reg <= s_tdata[9:2];
            p_bit_reg   <= s_tdata[10];
        end
    end

    hufd_loader #(
        .MAX_NODES   (MAX_NODES),
        .STACK_DEPTH (STACK_DEPTH),
        .NODE_W      (NODE_W)
    ) u_loader (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (p_valid_reg),
        .item_op    (p_op_reg),
        .item_token (p_token_reg),
        .sym_we     (sym_we),
        .sym_waddr  (sym_waddr),
        .sym_wdata  (sym_wdata),
        .left_we    (left_we),
        .right_we   (right_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .stat       (stat),
        .root_left  (root_left),
        .root_right (root_right),
        .load_res   (load_res)
    );

    hufd_node_table #(
        .MAX_NODES (MAX_NODES),
        .NODE_W    (NODE_W)
    ) u_node_table (
        .aclk       (aclk),
        .sym_we     (sym_we),
        .sym_waddr  (sym_waddr),
        .sym_wdata  (sym_wdata),
        .left_we    (left_we),
        .right_we   (right_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .raddr      (nt_raddr),
        .rd_leaf    (rd_leaf),
        .rd_sym     (rd_sym),
        .rd_left    (rd_left),
        .rd_right   (rd_right)
    );

    hufd_decoder #(
        .NODE_W (NODE_W)
    ) u_decoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (p_valid_reg),
        .item_op    (p_op_reg),
        .item_bit   (p_bit_reg),
        .stat       (stat),
        .root_left  (root_left),
        .root_right (root_right),
        .load_res   (load_res),
        .rd_leaf    (rd_leaf),
        .rd_sym     (rd_sym),
        .rd_left    (rd_left),
        .rd_right   (rd_right),
        .nt_raddr   (nt_raddr),
        .r_valid    (r_valid),
        .push       (push),
        .push_data  (push_data)
    );

    hufd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (m_tvalid && m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .count     (out_count)
    );

    assign m_tdata = {5'b0, out_data};

endmodule

// ===== design/hufd_node_table.sv =====
// ----------------------------------------------------------------------------
// hufd_node_table
// Node storage: leaf flag and symbol, left link, right link, each with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module hufd_node_table #(
    parameter int MAX_NODES = 512,
    parameter int NODE_W    = 9
) (
    input  logic              aclk,
    input  logic              sym_we,
    input  logic [NODE_W-1:0] sym_waddr,
    input  logic [8:0]        sym_wdata,
    input  logic              left_we,
    input  logic              right_we,
    input  logic [NODE_W-1:0] link_waddr,
    input  logic [NODE_W-1:0] link_wdata,
    input  logic [NODE_W-1:0] raddr,
    output logic              rd_leaf,
    output logic [7:0]        rd_sym,
    output logic [NODE_W-1:0] rd_left,
    output logic [NODE_W-1:0] rd_right
);

    logic [8:0]        sym_mem_reg   [MAX_NODES];
    logic [NODE_W-1:0] left_mem_reg  [MAX_NODES];
    logic [NODE_W-1:0] right_mem_reg [MAX_NODES];
    logic [8:0]        rd_sym_reg;
    logic [NODE_W-1:0] rd_left_reg;
    logic [NODE_W-1:0] rd_right_reg;

    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem_reg[sym_waddr] <= sym_wdata;
        end
        rd_sym_reg <= sym_mem_reg[raddr];
    end

    always_ff @(posedge aclk) begin
        if (left_we) begin
            left_mem_reg[link_waddr] <= link_wdata;
        end
        rd_left_reg <= left_mem_reg[raddr];
    end

    always_ff @(posedge aclk) begin
        if (right_we) begin
            right_mem_reg[link_waddr] <= link_wdata;
        end
        rd_right_reg <= right_mem_reg[raddr];
    end

    assign rd_leaf  = rd_sym_reg[8];
    assign rd_sym   = rd_sym_reg[7:0];
    assign rd_left  = rd_left_reg;
    assign rd_right = rd_right_reg;

endmodule

// ===== design/hufd_loader.sv =====
// ----------------------------------------------------------------------------
// hufd_loader
// Builds the tree from preorder tokens with a stack of pending parents; the
// top of stack is cached, deeper entries live in a memory.
// ----------------------------------------------------------------------------
module hufd_loader #(
    parameter int MAX_NODES   = 512,
    parameter int STACK_DEPTH = 256,
    parameter int NODE_W      = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    input  hufd_pkg::op_t         item_op,
    input  logic [7:0]            item_token,
    output logic                  sym_we,
    output logic [NODE_W-1:0]     sym_waddr,
    output logic [8:0]            sym_wdata,
    output logic                  left_we,
    output logic                  right_we,
    output logic [NODE_W-1:0]     link_waddr,
    output logic [NODE_W-1:0]     link_wdata,
    output hufd_pkg::tree_stat_t  stat,
    output logic [NODE_W-1:0]     root_left,
    output logic [NODE_W-1:0]     root_right,
    output hufd_pkg::load_res_t   load_res
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int STK_W = $clog2(STACK_DEPTH);
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);

    logic [LVL_W-1:0]  level_reg, level_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic              await_reg, await_next;
    logic              complete_reg, complete_next;
    logic              root_leaf_reg, root_leaf_next;
    logic [7:0]        root_sym_reg, root_sym_next;
    logic [NODE_W-1:0] root_left_reg, root_left_next;
    logic [NODE_W-1:0] root_right_reg, root_right_next;
    logic [NODE_W-1:0] top_par_reg, top_par_next;
    logic              top_rn_reg, top_rn_next;
    logic              top_mem_reg, top_mem_next;
    logic [NODE_W-1:0] stack_mem_reg [STACK_DEPTH];
    logic [NODE_W-1:0] stk_rd_reg;

    logic [NODE_W-1:0] top_par;
    logic              top_rn;
    logic [NODE_W-1:0] new_node;
    logic              node_full;
    logic              attach;
    logic              pop_now;
    logic [LVL_W-1:0]  level_after;
    logic [LVL_W-1:0]  level_m2;
    logic              stack_full;
    logic              stk_we;
    logic [STK_W-1:0]  stk_waddr;
    logic [STK_W-1:0]  stk_raddr;

    always_comb begin
        top_par     = top_mem_reg ? stk_rd_reg : top_par_reg;
        top_rn      = top_mem_reg || top_rn_reg;
        new_node    = used_reg[NODE_W-1:0];
        node_full   = used_reg >= CNT_W'(MAX_NODES);
        attach      = (used_reg != '0) && (level_reg != '0);
        pop_now     = attach && top_rn;
        level_after = level_reg - LVL_W'(pop_now);
        level_m2    = level_reg - LVL_W'(2);
        stack_full  = level_after >= LVL_W'(STACK_DEPTH);
        stk_waddr   = level_after[STK_W-1:0];
        stk_raddr   = level_m2[STK_W-1:0];
    end

    always_comb begin
        level_next      = level_reg;
        used_next       = used_reg;
        await_next      = await_reg;
        complete_next   = complete_reg;
        root_leaf_next  = root_leaf_reg;
        root_sym_next   = root_sym_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        top_par_next    = top_par;
        top_rn_next     = top_rn;
        top_mem_next    = 1'b0;
        stk_we          = 1'b0;
        sym_we          = 1'b0;
        sym_wdata       = '0;
        left_we         = 1'b0;
        right_we        = 1'b0;
        load_res        = '{valid: 1'b0, kind: hufd_pkg::KIND_SYMBOL};

        if (item_valid && item_op == hufd_pkg::OP_CLEAR) begin
            level_next     = '0;
            used_next      = '0;
            await_next     = 1'b0;
            complete_next  = 1'b0;
            root_leaf_next = 1'b0;
            top_rn_next    = 1'b0;
        end else if (item_valid && item_op == hufd_pkg::OP_TOKEN && !complete_reg) begin
            if (await_reg) begin
                // leaf symbol byte
                await_next = 1'b0;
                if (node_full) begin
                    load_res = '{valid: 1'b1, kind: hufd_pkg::KIND_OVERFLOW};
                end else begin
                    sym_we    = 1'b1;
                    sym_wdata = {1'b1, item_token};
                    used_next = used_reg + CNT_W'(1);
                    if (used_reg == '0) begin
                        root_leaf_next = 1'b1;
                        root_sym_next  = item_token;
                    end
                    if (attach) begin
                        if (!top_rn) begin
                            left_we     = 1'b1;
                            top_rn_next = 1'b1;
                            if (top_par == '0) begin
                                root_left_next = new_node;
                            end
                        end else begin
                            right_we   = 1'b1;
                            level_next = level_after;
                            if (top_par == '0) begin
                                root_right_next = new_node;
                            end
                            // fetch the new top from the stack memory
                            if (level_reg >= LVL_W'(2)) begin
                                top_mem_next = 1'b1;
                            end
                        end
                    end
                    if (level_after == '0) begin
                        complete_next = 1'b1;
                        load_res      = '{valid: 1'b1, kind: hufd_pkg::KIND_READY};
                    end
                end
            end else if (item_token == hufd_pkg::LEAF_MARK) begin
                await_next = 1'b1;
            end else if (node_full || stack_full) begin
                load_res = '{valid: 1'b1, kind: hufd_pkg::KIND_OVERFLOW};
            end else begin
                // internal node: attach, then push as new pending parent
                sym_we    = 1'b1;
                sym_wdata = '0;
                used_next = used_reg + CNT_W'(1);
                if (used_reg == '0) begin
                    root_leaf_next = 1'b0;
                end
                if (attach) begin
                    if (!top_rn) begin
                        left_we = 1'b1;
                        if (top_par == '0) begin
                            root_left_next = new_node;
                        end
                    end else begin
                        right_we = 1'b1;
                        if (top_par == '0) begin
                            root_right_next = new_node;
                        end
                    end
                end
                stk_we       = 1'b1;
                top_par_next = new_node;
                top_rn_next  = 1'b0;
                level_next   = level_after + LVL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= '0;
            used_reg      <= '0;
            await_reg     <= 1'b0;
            complete_reg  <= 1'b0;
            root_leaf_reg <= 1'b0;
            top_rn_reg    <= 1'b0;
            top_mem_reg   <= 1'b0;
        end else begin
            level_reg     <= level_next;
            used_reg      <= used_next;
            await_reg     <= await_next;
            complete_reg  <= complete_next;
            root_leaf_reg <= root_leaf_next;
            top_rn_reg    <= top_rn_next;
            top_mem_reg   <= top_mem_next;
        end
    end

    always_ff @(posedge aclk) begin
        root_sym_reg   <= root_sym_next;
        root_left_reg  <= root_left_next;
        root_right_reg <= root_right_next;
        top_par_reg    <= top_par_next;
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem_reg[stk_waddr] <= new_node;
        end
        stk_rd_reg <= stack_mem_reg[stk_raddr];
    end

    assign sym_waddr  = new_node;
    assign link_waddr = top_par;
    assign link_wdata = new_node;
    assign root_left  = root_left_reg;
    assign root_right = root_right_reg;
    assign stat       = '{complete: complete_reg, root_leaf: root_leaf_reg,
                          root_sym: root_sym_reg};

endmodule

// ===== design/hufd_decoder.sv =====
// ----------------------------------------------------------------------------
// hufd_decoder
// Walks the tree one code bit per request. The child read is registered and
// resolved in the result stage, which also forwards the new cursor.
// ----------------------------------------------------------------------------
module hufd_decoder #(
    parameter int NODE_W = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    input  hufd_pkg::op_t         item_op,
    input  logic                  item_bit,
    input  hufd_pkg::tree_stat_t  stat,
    input  logic [NODE_W-1:0]     root_left,
    input  logic [NODE_W-1:0]     root_right,
    input  hufd_pkg::load_res_t   load_res,
    input  logic                  rd_leaf,
    input  logic [7:0]            rd_sym,
    input  logic [NODE_W-1:0]     rd_left,
    input  logic [NODE_W-1:0]     rd_right,
    output logic [NODE_W-1:0]     nt_raddr,
    output logic                  r_valid,
    output logic                  push,
    output hufd_pkg::result_t     push_data
);

    logic              at_root_reg, at_root_next;
    logic [NODE_W-1:0] cur_left_reg, cur_left_next;
    logic [NODE_W-1:0] cur_right_reg, cur_right_next;
    logic              bits_seen_reg, bits_seen_next;
    logic              r_valid_reg, r_valid_next;
    logic              r_lookup_reg, r_lookup_next;
    hufd_pkg::kind_t   r_kind_reg, r_kind_next;
    logic [7:0]        r_sym_reg, r_sym_next;

    logic              eff_at_root;
    logic [NODE_W-1:0] eff_left;
    logic [NODE_W-1:0] eff_right;

    // Resolve the cursor: a pending lookup that hit a leaf returns to root.
    always_comb begin
        eff_at_root    = r_lookup_reg ? rd_leaf : at_root_reg;
        cur_left_next  = r_lookup_reg ? rd_left : cur_left_reg;
        cur_right_next = r_lookup_reg ? rd_right : cur_right_reg;
        eff_left       = eff_at_root ? root_left : cur_left_next;
        eff_right      = eff_at_root ? root_right : cur_right_next;
        nt_raddr       = item_bit ? eff_right : eff_left;
    end

    always_comb begin
        at_root_next   = eff_at_root;
        bits_seen_next = bits_seen_reg;
        r_valid_next   = 1'b0;
        r_lookup_next  = 1'b0;
        r_kind_next    = hufd_pkg::KIND_SYMBOL;
        r_sym_next     = '0;
        if (item_valid) begin
            case (item_op)
                hufd_pkg::OP_TOKEN: begin
                    r_valid_next = load_res.valid;
                    r_kind_next  = load_res.kind;
                end
                hufd_pkg::OP_BIT: begin
                    r_valid_next = 1'b1;
                    if (!stat.complete) begin
                        r_kind_next = hufd_pkg::KIND_NOTREE;
                    end else begin
                        bits_seen_next = 1'b1;
                        if (stat.root_leaf) begin
                            at_root_next = 1'b1;
                            r_sym_next   = stat.root_sym;
                        end else begin
                            r_lookup_next = 1'b1;
                        end
                    end
                end
                hufd_pkg::OP_FINISH: begin
                    r_valid_next = 1'b1;
                    if (!stat.complete) begin
                        r_kind_next = hufd_pkg::KIND_NOTREE;
                    end else begin
                        r_kind_next = (bits_seen_reg && eff_at_root) ?
                                      hufd_pkg::KIND_OK : hufd_pkg::KIND_MISMATCH;
                        at_root_next   = 1'b1;
                        bits_seen_next = 1'b0;
                    end
                end
                hufd_pkg::OP_CLEAR: begin
                    at_root_next   = 1'b1;
                    bits_seen_next = 1'b0;
                end
                default: begin
                    r_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_root_reg   <= 1'b1;
            bits_seen_reg <= 1'b0;
            r_valid_reg   <= 1'b0;
            r_lookup_reg  <= 1'b0;
        end else begin
            at_root_reg   <= at_root_next;
            bits_seen_reg <= bits_seen_next;
            r_valid_reg   <= r_valid_next;
            r_lookup_reg  <= r_lookup_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_left_reg  <= cur_left_next;
        cur_right_reg <= cur_right_next;
        r_kind_reg    <= r_kind_next;
        r_sym_reg     <= r_sym_next;
    end

    // A lookup emits only when the child is a leaf.
    assign r_valid          = r_valid_reg;
    assign push             = r_valid_reg && (!r_lookup_reg || rd_leaf);
    assign push_data.kind   = r_lookup_reg ? hufd_pkg::KIND_SYMBOL : r_kind_reg;
    assign push_data.symbol = r_lookup_reg ? rd_sym : r_sym_reg;

endmodule

// ===== design/hufd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// hufd_out_fifo
// Small result queue that decouples the pipeline from the receiver.
// ----------------------------------------------------------------------------
module hufd_out_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  hufd_pkg::result_t                 push_data,
    input  logic                              pop,
    output logic                              out_valid,
    output hufd_pkg::result_t                 out_data,
    output logic [hufd_pkg::OUT_CNT_W-1:0]    count
);

    hufd_pkg::result_t                   mem_reg [hufd_pkg::OUT_DEPTH];
    logic [hufd_pkg::OUT_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hufd_pkg::OUT_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hufd_pkg::OUT_CNT_W-1:0]      cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + hufd_pkg::OUT_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + hufd_pkg::OUT_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + hufd_pkg::OUT_CNT_W'(push) - hufd_pkg::OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = cnt_reg;

endmodule

// ===== design/hufd_checker.sv =====
// ----------------------------------------------------------------------------
// hufd_checker
// Port-level checks of the Huffman tree loader and decoder, bound to the top.
// ----------------------------------------------------------------------------
`include "huffman_tree_load_and_decode_assert.svh"

module hufd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Only symbol results carry a nonzero symbol byte.
    `HUFD_ASSERT_IMP(a_sym_zero, aclk, aresetn, m_tvalid && (m_tdata[2:0] != hufd_pkg::KIND_SYMBOL), m_tdata[15:3] == 13'd0, "non-symbol result carries data")

    // A new result traces back through the pipeline to an accepted request.
    `HUFD_ASSERT_IMP(a_latency, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready, 3), "result without matching request")

    // Input backpressure only while results are waiting.
    `HUFD_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid, "input stalled with empty output")

    // Hold a stalled result.
    `HUFD_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    logic unused_in;
    assign unused_in = ^s_tdata;

endmodule

bind huffman_tree_load_and_decode hufd_checker u_hufd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
